>>> rtl/itar_pkg.sv
// Package for the integer-to-ASCII radix converter.
// Holds the field widths, radix limits, character codes and digit encoding.
// No dependencies; the top level and the divider import it.
package itar_pkg;

  // Field widths
  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 5;
  localparam int CHAR_W  = 8;

  // Default sizes, handed to the top level as parameter defaults
  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_DIGITS_DEF = 32;

  // Radix register limits
  localparam logic [RADIX_W-1:0] RADIX_RESET  = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN    = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX    = 6'd32;
  localparam logic [RADIX_W-1:0] SIGNED_RADIX = 6'd10;

  // Character codes
  localparam logic [CHAR_W-1:0] DIGIT_BASE  = 8'd48;
  localparam logic [CHAR_W-1:0] LETTER_BASE = 8'd65;
  localparam logic [CHAR_W-1:0] MINUS_CHAR  = 8'd45;
  localparam logic [CHAR_W-1:0] ZERO_CHAR   = 8'd48;
  localparam logic [DIGIT_W-1:0] LETTER_START = 5'd10;

  // Digit value to ASCII: 0..9 -> '0'..'9', 10 and up -> 'A' onward
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d >= LETTER_START) begin
      return LETTER_BASE + d_ext - {{(CHAR_W-DIGIT_W){1'b0}}, LETTER_START};
    end
    return DIGIT_BASE + d_ext;
  endfunction

endpackage

>>> rtl/integer_to_ascii_radix_unit.sv
// Top level of the integer-to-ASCII radix converter.
// Depends on itar_pkg, itar_divider and itar_ram.
//
// Usage:
//   Input stream (s_axis_*): one signed two's-complement integer per request.
//   Output stream (m_axis_*): its text, one ASCII character per request, most
//   significant digit first; tlast marks the last character. Zero gives "0";
//   a leading '-' appears for negative numbers in radix 10 only.
//   Config: cfg_we_i writes cfg_wdata_i to the radix register; values outside
//   2..32 are ignored. Write only while the block is idle.
// Timing:
//   Each digit comes from the bit-serial divider, one quotient bit per
//   cycle. Characters then leave through the digit RAM, each by a RAM read
//   and then an output register load.
//   32-bit values in radix 10 need up to 10 digits, in radix 2 up to 32.
//   One item is in work at a time; s_axis_tready is high while idle.
// Reset: radix returns to 10, the sequencer and the output register empty.
// Stall: a held output character blocks the next load; the sequencer waits
//   and nothing is lost. A new item may be accepted while the last
//   character of the previous one still waits in the output register.
module integer_to_ascii_radix_unit
  import itar_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // number [VALUE_BITS-1:0], zero padded to whole bytes
  input  logic [((VALUE_BITS+7)/8)*8-1:0]    s_axis_tdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // character [7:0]
  output logic [CHAR_W-1:0]                  m_axis_tdata,
  output logic                               m_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_we_i,
  input  logic [RADIX_W-1:0]                 cfg_wdata_i
);

  localparam int ADDR_W = $clog2(MAX_DIGITS);
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_ZERO = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [RADIX_W-1:0]    radix_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  neg_q, neg_d;
  logic                  out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]     out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;

  logic                  accept;
  logic                  out_free;
  logic [VALUE_BITS-1:0] number;
  logic [VALUE_BITS-1:0] magnitude;
  logic                  mag_zero;
  logic [CNT_W-1:0]      cnt_inc;
  logic [CNT_W-1:0]      cnt_dec;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]    div_rem;

  logic                  ram_re;
  logic [DIGIT_W-1:0]    ram_rdata;

  // Radix register; out-of-range writes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_we_i && cfg_wdata_i >= RADIX_MIN && cfg_wdata_i <= RADIX_MAX) begin
      radix_q <= cfg_wdata_i;
    end
  end

  // Input request and magnitude; the most negative value maps to 2^(N-1)
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign number        = s_axis_tdata[VALUE_BITS-1:0];
  assign magnitude     = number[VALUE_BITS-1] ? (~number + 1'b1) : number;
  assign mag_zero      = (magnitude == '0);

  assign out_free = !out_valid_q || m_axis_tready;
  assign cnt_inc  = cnt_q + 1'b1;
  assign cnt_dec  = cnt_q - 1'b1;

  // Divider control: first digit from the input, later ones from the quotient
  assign div_dividend = (state_q == S_IDLE) ? magnitude : div_quot;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    div_start   = 1'b0;
    ram_re      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          neg_d = number[VALUE_BITS-1];
          cnt_d = '0;
          if (mag_zero) begin
            state_d = S_ZERO;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          cnt_d = cnt_inc;
          if (div_quot != '0 && cnt_inc < MAX_CNT) begin
            div_start = 1'b1;
          end else begin
            state_d = S_SIGN;
          end
        end
      end
      S_ZERO: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = ZERO_CHAR;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_SIGN: begin
        if (neg_q && radix_q == SIGNED_RADIX && cnt_q < MAX_CNT) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_char_d  = MINUS_CHAR;
            out_last_d  = 1'b0;
            state_d     = S_RD;
          end
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = digit_to_ascii(ram_rdata);
          out_last_d  = (cnt_q == ONE_CNT);
          cnt_d       = cnt_dec;
          state_d     = (cnt_q == ONE_CNT) ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;

  itar_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (radix_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Digit store, least significant digit at address zero
  itar_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (div_done && state_q == S_DIV),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (div_rem),
    .re_i    (ram_re),
    .raddr_i (cnt_dec[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Digits are only written below the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> cnt_q < MAX_CNT)
    else $error("digit count reached store depth during division");

  // Reading back digits never starts with an empty store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_OUT) |-> cnt_q != '0)
    else $error("digit readback with zero digits stored");

  // A zero input goes straight to the single '0' character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && mag_zero |=> state_q == S_ZERO)
    else $error("zero input did not take the zero path");

  // Division results only arrive while the sequencer waits for them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the division state");

endmodule

>>> rtl/itar_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the digit store of the converter.
module itar_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/itar_divider.sv
// Bit-serial restoring divider: divides the magnitude by the radix,
// one quotient bit per cycle. Depends on itar_pkg for the radix and digit widths.
module itar_divider
  import itar_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [RADIX_W-1:0]    divisor_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] quot_o,
  output logic [DIGIT_W-1:0]    rem_o
);

  localparam int STEP_W = $clog2(VALUE_BITS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_BITS - 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [VALUE_BITS-1:0] dvd_q, dvd_d;
  logic [DIGIT_W-1:0]    rem_q, rem_d;
  logic [RADIX_W-1:0]    div_q, div_d;
  logic [RADIX_W-1:0]    trial;
  logic                  ge;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  assign trial = {rem_q, dvd_q[VALUE_BITS-1]};
  assign ge    = (trial >= div_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = ge ? DIGIT_W'(trial - div_q) : trial[DIGIT_W-1:0];
      dvd_d  = {dvd_q[VALUE_BITS-2:0], ge};
      step_d = step_q + 1'b1;
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule
